// ----- rtl/lzw_hashed_dictionary_compressor_top_macros.svh -----
// ----------------------------------------------------------------------------
// LZW compressor assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef LZW_HASHED_DICTIONARY_COMPRESSOR_TOP_MACROS_SVH
`define LZW_HASHED_DICTIONARY_COMPRESSOR_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define LZWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzw checker: implication failed");

// next-cycle implication, masked during reset
`define LZWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzw checker: next-cycle implication failed");

// next-cycle implication, checked in reset too
`define LZWC_ASSERT_NXT_RAW(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lzw checker: reset implication failed");

`endif

// ----- rtl/lzwd_pkg.sv -----
// ----------------------------------------------------------------------------
// LZW compressor package
// Request codes, fixed constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  // request type codes
  localparam logic [1:0] REQ_DATA   = 2'd0;
  localparam logic [1:0] REQ_END    = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_IGNORE = 2'd3;

  // output code width and special codes
  localparam int unsigned OUT_W      = 12;
  localparam logic [15:0] END_CODE   = 16'd256;
  localparam logic [15:0] FIRST_FREE = 16'd257;

  // controller -> datapath commands
  typedef struct packed {
    logic first;     // first byte of a stream starts the string
    logic load;      // latch byte, start hash reduction
    logic hstep;     // one hash reduction step
    logic cmp;       // evaluate probed slot
    logic end_item;  // flush string and end code
    logic clr_start; // restart clearing sweep
    logic clr_step;  // clear one slot
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic started;
    logic room;
    logic hash_last;
    logic more;
    logic clr_last;
  } sts_t;

endpackage

// ----- rtl/lzw_hashed_dictionary_compressor_top.sv -----
// ----------------------------------------------------------------------------
// LZW compressor with a hashed dictionary.
// Input channel (in_valid/in_ready): one beat per request. req_type 0 carries a
// data byte, 1 ends the stream, 2 clears the dictionary, 3 is ignored.
// Output channel (out_valid/out_ready): one beat per emitted code; out_last
// marks the end code 256 that closes each stream.
// Sequence: a data byte after a stream's first is accepted, its hash is reduced
// modulo the table size, then each probe of the single-port dictionary RAM reads
// and compares a slot. End and ignored items finish on acceptance; a clear item
// sweeps every RAM slot.
// Reset: a clearing sweep of all TABLE_ENTRIES slots runs with in_ready low.
// Results go into a four-beat queue; input is taken while at least two slots
// are free, so a stalled receiver holds the block only once fewer than two are free.
// ----------------------------------------------------------------------------
module lzw_hashed_dictionary_compressor_top #(
  parameter int CODE_BITS     = 12,
  parameter int TABLE_ENTRIES = 5021
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_req_type,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lzwd_pkg::OUT_W-1:0] out_code,
  output logic                       out_last
);
  import lzwd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lzwd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd)
  );

  lzwd_dp #(.CB(CODE_BITS), .TE(TABLE_ENTRIES)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_code     (out_code),
    .out_last     (out_last)
  );

endmodule

// ----- rtl/lzwd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int W = 33,
  parameter int D = 5021
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/lzwd_ctrl.sv -----
// ----------------------------------------------------------------------------
// LZW compressor controller
// Sequences clearing sweep, hash reduction and dictionary probing.
// ----------------------------------------------------------------------------
module lzwd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_req_type,
  input  lzwd_pkg::sts_t sts,
  output lzwd_pkg::cmd_t cmd
);
  import lzwd_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       acc;

  assign in_ready = (state_r == S_IDLE) && sts.room;
  assign acc      = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          unique case (in_req_type)
            REQ_DATA: begin
              if (!sts.started) begin
                cmd.first = 1'b1;
              end else begin
                cmd.load  = 1'b1;
                state_nxt = S_HASH;
              end
            end
            REQ_END: cmd.end_item = 1'b1;
            REQ_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_HASH: begin
        cmd.hstep = 1'b1;
        if (sts.hash_last) state_nxt = S_RD;
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = sts.more ? S_RD : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/lzwd_dp.sv -----
// ----------------------------------------------------------------------------
// LZW compressor datapath
// String state, hash reduction, probe address, dictionary RAM, result queue.
// ----------------------------------------------------------------------------
module lzwd_dp #(
  parameter int CB = 12,
  parameter int TE = 5021
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lzwd_pkg::cmd_t             cmd,
  output lzwd_pkg::sts_t             sts,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lzwd_pkg::OUT_W-1:0] out_code,
  output logic                       out_last
);
  import lzwd_pkg::*;

  localparam int AW  = $clog2(TE);
  localparam int HQ  = $clog2(((1 << CB) - 1) / TE + 1);
  localparam int HS  = (HQ < 1) ? 1 : HQ;
  localparam int HCW = (HS > 1) ? $clog2(HS) : 1;
  localparam int DW  = AW + HS + CB;
  localparam int EW  = 1 + 2 * CB + 8;

  // item and string state
  logic [7:0]    byte_r;
  logic [CB-1:0] cur_r, cur_nxt;
  logic [CB:0]   nfc_r, nfc_nxt;
  logic          started_r, started_nxt;

  // hash reduction
  logic [CB-1:0]  r_r, r_nxt;
  logic [HCW-1:0] hcnt_r;
  logic [DW-1:0]  dk;

  // probe address
  logic [AW-1:0] idx_r, start_r, step, nidx;
  logic [AW-1:0] clr_r;

  // RAM
  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;
  logic          s_used, s_match;
  logic [CB-1:0] s_code, s_parent;
  logic [7:0]    s_byte;

  // result queue
  logic [OUT_W-1:0] q_code_r [4];
  logic             q_last_r [4];
  logic [1:0]       wp_r, rp_r;
  logic [2:0]       cnt_r;
  logic             push_a, push_b, pop;
  logic [OUT_W-1:0] code_a, code_b;
  logic             last_a;
  logic [15:0]      cur_w;

  // hash reduced modulo the table size, largest multiple first
  assign dk    = DW'(TE) << hcnt_r;
  assign r_nxt = (DW'(r_r) >= dk) ? (r_r - dk[CB-1:0]) : r_r;

  // probe step and wrapped next slot
  assign step = (start_r == '0) ? AW'(1) : AW'(AW'(TE) - start_r);
  assign nidx = (idx_r >= step) ? AW'(idx_r - step) : AW'(idx_r + AW'(TE) - step);

  // slot fields
  assign s_used   = rdata[EW-1];
  assign s_code   = rdata[EW-2 -: CB];
  assign s_parent = rdata[CB+7 -: CB];
  assign s_byte   = rdata[7:0];
  assign s_match  = s_used && (s_parent == cur_r) && (s_byte == byte_r);

  assign addr  = cmd.clr_step ? clr_r : idx_r;
  assign we    = cmd.clr_step || (cmd.cmp && !s_used && !nfc_r[CB]);
  assign wdata = cmd.clr_step ? '0 : {1'b1, nfc_r[CB-1:0], cur_r, byte_r};

  lzwd_ram #(.W(EW), .D(TE)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign cur_w = 16'(cur_r);

  // string state and queue pushes
  always_comb begin
    cur_nxt     = cur_r;
    nfc_nxt     = nfc_r;
    started_nxt = started_r;
    push_a      = 1'b0;
    push_b      = 1'b0;
    code_a      = cur_w[OUT_W-1:0];
    last_a      = 1'b0;
    code_b      = END_CODE[OUT_W-1:0];
    if (cmd.first) begin
      cur_nxt     = CB'(in_data_byte);
      started_nxt = 1'b1;
    end
    if (cmd.cmp) begin
      if (s_match) begin
        cur_nxt = s_code;
      end else begin
        if (!s_used && !nfc_r[CB]) nfc_nxt = nfc_r + 1'b1;
        if (!s_used || (nidx == start_r)) begin
          push_a  = 1'b1;
          cur_nxt = CB'(byte_r);
        end
      end
    end
    if (cmd.end_item) begin
      push_a = 1'b1;
      if (started_r) begin
        push_b = 1'b1;
      end else begin
        code_a = END_CODE[OUT_W-1:0];
        last_a = 1'b1;
      end
      cur_nxt     = CB'(END_CODE);
      nfc_nxt     = (CB+1)'(FIRST_FREE);
      started_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= CB'(END_CODE);
      nfc_r     <= (CB+1)'(FIRST_FREE);
      started_r <= 1'b0;
      clr_r     <= '0;
      wp_r      <= '0;
      rp_r      <= '0;
      cnt_r     <= '0;
    end else begin
      cur_r     <= cur_nxt;
      nfc_r     <= nfc_nxt;
      started_r <= started_nxt;
      if (cmd.clr_start) clr_r <= '0;
      else if (cmd.clr_step) clr_r <= (clr_r == AW'(TE - 1)) ? '0 : AW'(clr_r + 1'b1);
      wp_r  <= wp_r + {1'b0, push_a} + {1'b0, push_b};
      rp_r  <= rp_r + {1'b0, pop};
      cnt_r <= cnt_r + {2'b0, push_a} + {2'b0, push_b} - {2'b0, pop};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_data_byte;
      hcnt_r <= HCW'(HS - 1);
    end
    if (cmd.load) r_r <= (CB'(in_data_byte) << (CB - 8)) ^ cur_r;
    else if (cmd.hstep) begin
      r_r    <= r_nxt;
      hcnt_r <= hcnt_r - 1'b1;
    end
    if (cmd.hstep && (hcnt_r == '0)) begin
      idx_r   <= AW'(r_nxt);
      start_r <= AW'(r_nxt);
    end else if (cmd.cmp) begin
      idx_r <= nidx;
    end
    if (push_a) begin
      q_code_r[wp_r] <= code_a;
      q_last_r[wp_r] <= last_a;
    end
    if (push_b) begin
      q_code_r[wp_r + 2'd1] <= code_b;
      q_last_r[wp_r + 2'd1] <= 1'b1;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_code  = q_code_r[rp_r];
  assign out_last  = q_last_r[rp_r];
  assign pop       = out_valid && out_ready;

  assign sts.started   = started_r;
  assign sts.room      = (cnt_r <= 3'd2);
  assign sts.hash_last = (hcnt_r == '0);
  assign sts.more      = s_used && !s_match && (nidx != start_r);
  assign sts.clr_last  = (clr_r == AW'(TE - 1));

endmodule

// ----- rtl/lzwd_chk.sv -----
// ----------------------------------------------------------------------------
// LZW compressor port checker
// Watches the top level's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "lzw_hashed_dictionary_compressor_top_macros.svh"

module lzwd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_code,
  input logic        out_last
);
  import lzwd_pkg::*;

  // stalled result beat holds
  `LZWC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_code) && $stable(out_last))
  // reset starts the clearing sweep, so no input is taken next
  `LZWC_ASSERT_NXT_RAW(a_rst_busy, clk, !rst_n, !in_ready)
  // the closing beat of a stream is the end code
  `LZWC_ASSERT_IMP(a_last_end, clk, rst_n, out_valid && out_last, out_code == END_CODE[11:0])
  // an end item produces output right away
  `LZWC_ASSERT_NXT(a_end_out, clk, rst_n, in_valid && in_ready && (in_req_type == REQ_END), out_valid)

endmodule

bind lzw_hashed_dictionary_compressor_top lzwd_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_req_type (in_req_type),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_code    (out_code),
  .out_last    (out_last)
);
